>>> rtl/utf8s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8s_pkg;

  // Replacement sequence EF BF BD, indexed in order of emission.
  localparam logic [2:0][7:0] REPL_BYTES = {8'hBD, 8'hBF, 8'hEF};

  // Continuation bytes still needed after a lead byte.
  localparam logic [1:0] NEED_NONE  = 2'd0;
  localparam logic [1:0] NEED_ONE   = 2'd1;
  localparam logic [1:0] NEED_TWO   = 2'd2;
  localparam logic [1:0] NEED_THREE = 2'd3;

  // Output work produced by one input item: a number of replacement
  // sequences followed by a number of literal bytes.
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lit;
    logic            last;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/utf8s_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8s_decode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  output utf8s_pkg::job_t       job_o,
  output logic                  has_output_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_cnt_q, held_cnt_d;
  logic [1:0]      seq_len_q, seq_len_d;

  logic            is_cont;
  logic [1:0]      need;
  logic [2:0]      rep_pre;

  // Classify the incoming byte.
  assign is_cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    if (byte_i[7:5] == 3'b110) begin
      need = utf8s_pkg::NEED_ONE;
    end else if (byte_i[7:4] == 4'b1110) begin
      need = utf8s_pkg::NEED_TWO;
    end else if (byte_i[7:3] == 5'b11110) begin
      need = utf8s_pkg::NEED_THREE;
    end else begin
      need = utf8s_pkg::NEED_NONE;
    end
  end

  // Work out the output job and the next holding state.
  always_comb begin
    job_o.rep_cnt = 3'd0;
    job_o.lit_cnt = 3'd0;
    job_o.lit     = {4{byte_i}};
    job_o.last    = last_i;
    held_d        = held_q;
    held_cnt_d    = held_cnt_q;
    seq_len_d     = seq_len_q;
    rep_pre       = (seq_len_q != 2'd0) ? {1'b0, held_cnt_q} : 3'd0;

    if (seq_len_q != 2'd0 && is_cont) begin
      if (held_cnt_q == seq_len_q) begin
        // Sequence complete: held bytes followed by this byte.
        for (int k = 0; k < 3; k++) begin
          if (k < int'(held_cnt_q)) begin
            job_o.lit[k] = held_q[k];
          end
        end
        job_o.lit_cnt = {1'b0, held_cnt_q} + 3'd1;
        held_cnt_d    = 2'd0;
        seq_len_d     = 2'd0;
      end else if (last_i || held_cnt_q == 2'd3) begin
        // String ends inside a sequence: every byte is replaced.
        job_o.rep_cnt = {1'b0, held_cnt_q} + 3'd1;
        held_cnt_d    = 2'd0;
        seq_len_d     = 2'd0;
      end else begin
        held_d[held_cnt_q] = byte_i;
        held_cnt_d         = held_cnt_q + 2'd1;
      end
    end else begin
      // Any held bytes are broken; then the byte is handled afresh.
      held_cnt_d = 2'd0;
      seq_len_d  = 2'd0;
      if (!byte_i[7]) begin
        job_o.rep_cnt = rep_pre;
        job_o.lit_cnt = 3'd1;
      end else if (need != utf8s_pkg::NEED_NONE && !last_i) begin
        job_o.rep_cnt = rep_pre;
        held_d[0]     = byte_i;
        held_cnt_d    = 2'd1;
        seq_len_d     = need;
      end else begin
        job_o.rep_cnt = rep_pre + 3'd1;
      end
    end
  end

  assign has_output_o = (job_o.rep_cnt != 3'd0) || (job_o.lit_cnt != 3'd0);

  // Holding state, updated on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      seq_len_q  <= 2'd0;
    end else if (accept_i) begin
      held_cnt_q <= held_cnt_d;
      seq_len_q  <= seq_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8s_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8s_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  utf8s_pkg::job_t      job_i,
  output logic                 job_free_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 run_last_o,
  output logic                 string_end_o
);

  logic            busy_q, busy_d;
  logic [2:0]      rep_q, rep_d;
  logic [1:0]      tri_q, tri_d;
  logic [2:0]      lit_cnt_q;
  logic [1:0]      idx_q, idx_d;
  logic [3:0][7:0] lit_q;
  logic            last_q;

  logic            step;
  logic            final_byte;
  logic [7:0]      cur_byte;

  // Byte the sequencer presents this cycle.
  assign cur_byte   = (rep_q != 3'd0) ? utf8s_pkg::REPL_BYTES[tri_q] : lit_q[idx_q];
  assign final_byte = (rep_q != 3'd0)
                      ? (rep_q == 3'd1 && tri_q == 2'd2 && lit_cnt_q == 3'd0)
                      : ({1'b0, idx_q} + 3'd1 == lit_cnt_q);
  assign step       = busy_q && (!out_valid_o || out_ready_i);
  assign job_free_o = !busy_q || (step && final_byte);

  // Sequencer advance and job load.
  always_comb begin
    busy_d = busy_q;
    rep_d  = rep_q;
    tri_d  = tri_q;
    idx_d  = idx_q;
    if (step) begin
      if (final_byte) begin
        busy_d = 1'b0;
      end else if (rep_q != 3'd0) begin
        if (tri_q == 2'd2) begin
          tri_d = 2'd0;
          rep_d = rep_q - 3'd1;
        end else begin
          tri_d = tri_q + 2'd1;
        end
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      busy_d = 1'b1;
      rep_d  = job_i.rep_cnt;
      tri_d  = 2'd0;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rep_q  <= 3'd0;
      tri_q  <= 2'd0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      rep_q  <= rep_d;
      tri_q  <= tri_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lit_cnt_q <= job_i.lit_cnt;
      lit_q     <= job_i.lit;
      last_q    <= job_i.last;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (step) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_o   <= cur_byte;
      run_last_o   <= final_byte;
      string_end_o <= final_byte && last_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8_sanitizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    in_byte_i, in_last_i
// out      output     out_valid_o / out_ready_i  out_byte_o, run_last_o, string_end_o
//
// One output byte leaves per cycle while out_ready_i is high; an input item
// occupies the byte sequencer until all the bytes it produces (0 to 12) have
// left it, and an item that produces no bytes does not occupy it at all.
// The sequencer feeds a one-entry output register, so a new item is taken
// in the cycle its predecessor's final byte moves to that register.
// Reset clears the holding state and both valid flags; out_ready_i low
// stalls the sequencer and, through it, the input.

module utf8_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_end_o
);

  utf8s_pkg::job_t job;
  logic            has_output;
  logic            in_xfer;
  logic            job_free;

  assign in_ready_o = job_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Classification and holding state.
  utf8s_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_xfer),
    .byte_i       (in_byte_i),
    .last_i       (in_last_i),
    .job_o        (job),
    .has_output_o (has_output)
  );

  // Byte sequencer and output register.
  utf8s_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_xfer && has_output),
    .job_i        (job),
    .job_free_o   (job_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

`default_nettype wire

>>> rtl/utf8s_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8s_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       run_last_o,
  input wire logic       string_end_o
);

  // A stalled output byte holds with its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(string_end_o))
    else $error("stalled output changed");

  // The end of a string is always the end of an item's run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end without run end");

  // Only multi-byte sequences and replacements span several bytes, so a
  // byte that is not final in its run is never ASCII.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> out_byte_o[7])
    else $error("ASCII byte inside a run");

endmodule

bind utf8_sanitizer utf8s_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .run_last_o   (run_last_o),
  .string_end_o (string_end_o)
);

`default_nettype wire

>>> verif/utf8_sanitizer_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the sanitiser, predicts the output byte stream for
// every input transfer and compares each output transfer against it.
module utf8_sanitizer_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        in_last_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [7:0]  out_byte_i,
  input  wire logic        run_last_i,
  input  wire logic        string_end_i,
  output int unsigned      mismatch_cnt_o,
  output int unsigned      pending_o,
  output int unsigned      checked_o,
  output int unsigned      repl_cnt_o
);

  localparam int unsigned MAX_RUN    = 12;
  localparam int unsigned MAX_REPORT = 10;

  // Bit patterns that classify a byte.
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } san_byte_t;

  // Predicted decoder state.
  logic [7:0] held [3];
  logic [1:0] held_cnt;
  logic [1:0] need_cnt;

  // Bytes produced by the current input transfer, and all bytes still due.
  san_byte_t step_q [$];
  san_byte_t due_q [$];

  int unsigned errs;
  int unsigned checked;
  int unsigned repl_cnt;
  san_byte_t   want;

  function automatic void put_byte(input logic [7:0] b);
    san_byte_t e;
    e.data     = b;
    e.run_last = 1'b0;
    e.str_end  = 1'b0;
    if (step_q.size() < MAX_RUN) step_q.insert(step_q.size(), e);
  endfunction

  function automatic void put_repl();
    for (int k = 0; k < 3; k++) put_byte(utf8s_pkg::REPL_BYTES[k]);
    repl_cnt++;
  endfunction

  // Every held byte turns into a replacement sequence.
  function automatic void flush_held();
    for (int k = 0; k < held_cnt; k++) put_repl();
    held_cnt = 2'd0;
    need_cnt = utf8s_pkg::NEED_NONE;
  endfunction

  // Works out the output bytes caused by one input byte and queues them.
  function automatic void sanitise_byte(input logic [7:0] b, input logic last);
    logic       fresh;
    logic [1:0] need;
    fresh = 1'b1;
    need  = utf8s_pkg::NEED_NONE;
    step_q.delete();

    // A sequence is open: the byte either extends it or breaks it.
    if (need_cnt != utf8s_pkg::NEED_NONE) begin
      if (b[7:6] == CONT_TAG) begin
        fresh = 1'b0;
        if (held_cnt == need_cnt) begin
          for (int k = 0; k < held_cnt; k++) put_byte(held[k]);
          put_byte(b);
          held_cnt = 2'd0;
          need_cnt = utf8s_pkg::NEED_NONE;
        end else if (last) begin
          flush_held();
          put_repl();
        end else if (held_cnt < 2'd3) begin
          held[held_cnt] = b;
          held_cnt++;
        end else begin
          flush_held();
          put_repl();
        end
      end else begin
        flush_held();
      end
    end

    // The byte is taken on its own merits.
    if (fresh) begin
      if (!b[7]) put_byte(b);
      else if (b[7:5] == LEAD2_TAG) need = utf8s_pkg::NEED_ONE;
      else if (b[7:4] == LEAD3_TAG) need = utf8s_pkg::NEED_TWO;
      else if (b[7:3] == LEAD4_TAG) need = utf8s_pkg::NEED_THREE;
      else put_repl();

      if (need != utf8s_pkg::NEED_NONE) begin
        if (last) begin
          put_repl();
        end else begin
          held[0]  = b;
          held_cnt = 2'd1;
          need_cnt = need;
        end
      end
    end

    if (last && need_cnt != utf8s_pkg::NEED_NONE) flush_held();

    // Mark the end of this run and, on the final byte, of the string.
    if (step_q.size() > 0) begin
      step_q[step_q.size() - 1].run_last = 1'b1;
      step_q[step_q.size() - 1].str_end  = last;
    end
    foreach (step_q[k]) due_q.insert(due_q.size(), step_q[k]);
  endfunction

  // Predict on input transfers, compare on output transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt = 2'd0;
      need_cnt = utf8s_pkg::NEED_NONE;
      due_q.delete();
      errs     = 0;
      checked  = 0;
      repl_cnt = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      repl_cnt_o     <= 0;
    end else begin
      if (in_valid_i && in_ready_i) sanitise_byte(in_byte_i, in_last_i);

      if (out_valid_i && out_ready_i) begin
        checked++;
        if (due_q.size() == 0) begin
          if (errs < MAX_REPORT) begin
            $display("%0t: unexpected output byte %h run_last %b string_end %b",
                     $realtime, out_byte_i, run_last_i, string_end_i);
          end
          errs++;
        end else begin
          want = due_q.pop_front();
          if (want.data != out_byte_i || want.run_last != run_last_i ||
              want.str_end != string_end_i) begin
            if (errs < MAX_REPORT) begin
              $display("%0t: output mismatch: byte %h/%h run_last %b/%b string_end %b/%b",
                       $realtime, want.data, out_byte_i, want.run_last, run_last_i,
                       want.str_end, string_end_i);
              $display("  (values are expected/actual)");
            end
            errs++;
          end
        end
      end

      mismatch_cnt_o <= errs;
      pending_o      <= due_q.size();
      checked_o      <= checked;
      repl_cnt_o     <= repl_cnt;
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Drives byte strings into the sanitiser and lets the checker judge the output.
module testbench;

  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned RANDOM_ITEMS = 225;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_end_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned repl_seqs;
  int unsigned sent;
  int unsigned strings;
  int unsigned quiet_cycles;
  bit          src_gaps    = 1'b1;
  bit          sink_stalls = 1'b1;
  logic [7:0]  str_q [$];

  utf8_sanitizer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

  utf8_sanitizer_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_i     (out_byte_o),
    .run_last_i     (run_last_o),
    .string_end_i   (string_end_o),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked),
    .repl_cnt_o     (repl_seqs)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one byte, with random idle cycles ahead of it, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (src_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    sent++;
    if (last) strings++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Appends one byte to the string being built.
  function automatic void append_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  // Appends a lead byte for a sequence of the given length.
  function automatic void push_lead(input int unsigned len);
    logic [7:0] r;
    r = $urandom;
    case (len)
      2: append_byte({3'b110, r[4:0]});
      3: append_byte({4'b1110, r[3:0]});
      default: append_byte({5'b11110, r[2:0]});
    endcase
  endfunction

  function automatic void push_cont();
    logic [7:0] r;
    r = $urandom;
    append_byte({2'b10, r[5:0]});
  endfunction

  // Mostly well-formed characters, with truncated sequences and noise mixed in.
  function automatic void add_token();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  r;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    r    = $urandom;
    if (pick < 35) begin
      append_byte({1'b0, r[6:0]});
    end else if (pick < 75) begin
      push_lead(len);
      repeat (len - 1) push_cont();
    end else if (pick < 85) begin
      push_lead(len);
      repeat ($urandom_range(0, len - 2)) push_cont();
    end else if (pick < 92) begin
      push_cont();
    end else if (pick < 96) begin
      append_byte({5'b11111, r[2:0]});
    end else begin
      append_byte(r);
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off so that the block backs up.
  initial begin : sink
    int unsigned taken;
    bit          held_off;
    taken    = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) taken++;
      if (!held_off && taken >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= !(sink_stalls && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n_str;
    int unsigned n_tok;
    sent    = 0;
    strings = 0;
    n_str   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII extremes, then complete two-, three- and four-byte characters.
    send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // Stray continuation and bytes that can never start a character.
    send_byte(8'h80, 1'b0); send_byte(8'hF8, 1'b0); send_byte(8'hFF, 1'b0);
    // Sequence broken by an ASCII byte.
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    // String ends inside a four-byte sequence.
    send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'hBF, 1'b1);
    // Lead byte as the final byte of a string.
    send_byte(8'hDF, 1'b1);
    // Three bytes held, then broken by a new lead, then ended by ASCII.
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h00, 1'b1);

    // Random strings; a stretch of them runs with no idling on either side.
    while (sent < 25 + RANDOM_ITEMS) begin
      src_gaps    = !(n_str >= 10 && n_str < 20);
      sink_stalls = src_gaps;
      str_q.delete();
      n_tok = $urandom_range(1, 5);
      repeat (n_tok) add_token();
      foreach (str_q[k]) send_byte(str_q[k], k == str_q.size() - 1);
      n_str++;
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    // Drain, then allow time for any stray output.
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d output bytes, %0d replacements.",
             sent, strings, checked, repl_seqs);
    $display("Run included a %0d-cycle receiver hold-off and a stretch without idling.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
